// File: hdl/ibfd_pkg.sv
// shared types and constants for the imu binary frame deframer
`timescale 1ns / 1ps

package ibfd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam int NUM_REGS = 6;
  localparam int FLEN_W = 6;

  // configuration register indexes
  localparam logic [2:0] REG_QUAT  = 3'd0;
  localparam logic [2:0] REG_GYRO  = 3'd1;
  localparam logic [2:0] REG_ACCEL = 3'd2;
  localparam logic [2:0] REG_MAG   = 3'd3;
  localparam logic [2:0] REG_TEMP  = 3'd4;
  localparam logic [2:0] REG_TIME  = 3'd5;

  // per-cycle control for the byte chain
  typedef struct packed {
    logic       shift;
    logic       wr;
    logic [7:0] wr_data;
  } cell_ctrl_t;

  // payload word count from the enable registers
  function automatic logic [3:0] word_count(input logic [NUM_REGS-1:0] regs);
    logic [3:0] n;
    n = regs[REG_QUAT] ? 4'd4 : 4'd3;
    if (regs[REG_GYRO])  n = n + 4'd3;
    if (regs[REG_ACCEL]) n = n + 4'd3;
    if (regs[REG_MAG])   n = n + 4'd3;
    if (regs[REG_TEMP])  n = n + 4'd1;
    if (regs[REG_TIME])  n = n + 4'd1;
    return n;
  endfunction

endpackage

// File: hdl/ibfd_cell.sv
// one byte cell of the frame buffer chain
`timescale 1ns / 1ps

module ibfd_cell (
  input  logic               clk,
  input  ibfd_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         next_byte,
  output logic [7:0]         data
);
  import ibfd_pkg::*;

  // write wins over shift, so a full buffer can drop and append at once
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      data <= ctrl.wr_data;
    end else if (ctrl.shift) begin
      data <= next_byte;
    end
  end

endmodule

// File: hdl/ibfd_chain.sv
// ring of byte cells holding the frame buffer, head at cell 0
`timescale 1ns / 1ps

module ibfd_chain #(
  parameter int DEPTH = 34,
  parameter int IDXW  = 6
) (
  input  logic                 clk,
  input  ibfd_pkg::cell_ctrl_t ctrl,
  input  logic [IDXW-1:0]      wr_pos,
  output logic [7:0]           head0,
  output logic [7:0]           head1
);
  import ibfd_pkg::*;

  logic [7:0]  bytes [DEPTH];
  cell_ctrl_t  cctrl [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign cctrl[i] = '{shift:   ctrl.shift,
                          wr:      ctrl.wr && (wr_pos == IDXW'(i)),
                          wr_data: ctrl.wr_data};
      // last cell takes from cell 0, so a full pass of shifts is a rotation
      ibfd_cell u_cell (
        .clk       (clk),
        .ctrl      (cctrl[i]),
        .next_byte (bytes[(i + 1) % DEPTH]),
        .data      (bytes[i])
      );
    end
  endgenerate

  assign head0 = bytes[0];
  assign head1 = bytes[1];

endmodule

// File: hdl/imu_binary_frame_deframer.sv
// top level of the imu binary frame deframer
`timescale 1ns / 1ps

// Byte-stream frame parser for a binary IMU link. Each input transaction
// appends one rx_byte to a frame buffer kept in a ring of MAX_FRAME_BYTES
// byte cells that shift toward cell 0. The frame is 0x55 0x55, a number of
// big-endian 16-bit words set by the enable registers, and a big-endian
// 16-bit byte-sum trailer. When the buffer reaches frame length the block
// stalls its input while it drops bytes ahead of the first sync pair (one
// per cycle), rotates the whole ring once to sum the bytes and pick up the
// trailer, compares, and then either sends one error transaction and drops
// one byte, or sends the frame's words one after another, output stall
// permitting. Results sit in an output register, so a finished word may
// wait on the output side while new bytes come in. A pending configuration
// write stalls the byte input, and a write to a listed register empties
// the buffer. Counters saturate at COUNTER_BITS and are shown clipped to
// 16 bits.
module imu_binary_frame_deframer #(
  parameter int MAX_FRAME_BYTES = 34,
  parameter int COUNTER_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [3:0]  value_index,
  output logic [15:0] raw_value,
  output logic        last_value,
  output logic [15:0] good_frame_count,
  output logic [15:0] checksum_error_count,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic        cfg_data
);
  import ibfd_pkg::*;

  localparam int FW   = $clog2(MAX_FRAME_BYTES + 1);   // fill level width
  localparam int IDXW = $clog2(MAX_FRAME_BYTES);       // cell index width
  localparam int LW   = (FW > FLEN_W) ? FW : FLEN_W;   // compare width
  localparam int CW   = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  // state codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_ERR    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]              state, state_next;
  logic [FW-1:0]           fill, fill_next;
  logic [NUM_REGS-1:0]     regs;
  logic [15:0]             sum, sum_next;
  logic [15:0]             trl, trl_next;
  logic [IDXW-1:0]         rot, rot_next;
  logic [FLEN_W-1:0]       pos, pos_next;
  logic [COUNTER_BITS-1:0] good_cnt, good_cnt_next;
  logic [COUNTER_BITS-1:0] err_cnt, err_cnt_next;

  // chain interface
  cell_ctrl_t      cctrl;
  logic [IDXW-1:0] wr_pos;
  logic [7:0]      head0, head1;

  // output register controls
  logic        load;
  logic        load_status;
  logic [3:0]  load_index;
  logic [15:0] load_value;
  logic        load_last;

  logic              in_acc, cfg_acc, slot_free;
  logic [3:0]        words;
  logic [FLEN_W-1:0] flen;
  logic              flen_fits;
  logic              fill_full;
  logic [LW-1:0]     fill_x, flen_x, rot_x;
  logic              pair_at_head;
  logic              emit_last;

  ibfd_chain #(
    .DEPTH (MAX_FRAME_BYTES),
    .IDXW  (IDXW)
  ) u_chain (
    .clk    (clk),
    .ctrl   (cctrl),
    .wr_pos (wr_pos),
    .head0  (head0),
    .head1  (head1)
  );

  assign words     = word_count(regs);
  assign flen      = FLEN_W'(4) + {1'b0, words, 1'b0};
  assign fill_x    = LW'(fill);
  assign flen_x    = LW'(flen);
  assign rot_x     = LW'(rot);
  assign flen_fits = flen_x <= LW'(MAX_FRAME_BYTES);
  assign fill_full = fill == FW'(MAX_FRAME_BYTES);

  // a pending register write holds off the byte input
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign slot_free = !out_valid || !out_stall;

  assign pair_at_head = (head0 == SYNC_BYTE) && (head1 == SYNC_BYTE);
  // last word's first byte sits at frame length minus four
  assign emit_last    = pos == (flen - FLEN_W'(4));

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    sum_next      = sum;
    trl_next      = trl;
    rot_next      = rot;
    pos_next      = pos;
    good_cnt_next = good_cnt;
    err_cnt_next  = err_cnt;
    cctrl         = '{shift: 1'b0, wr: 1'b0, wr_data: rx_byte};
    wr_pos        = fill_full ? IDXW'(MAX_FRAME_BYTES - 1) : fill[IDXW-1:0];
    load          = 1'b0;
    load_status   = 1'b0;
    load_index    = 4'd0;
    load_value    = {head0, head1};
    load_last     = 1'b0;

    case (state)
      S_IDLE: begin
        if (cfg_acc) begin
          // only a listed register empties the buffer
          if (cfg_index < 3'(NUM_REGS)) begin
            fill_next = '0;
          end
        end else if (in_acc) begin
          cctrl.wr = 1'b1;
          // a full buffer drops its oldest byte while the new one lands
          if (fill_full) begin
            cctrl.shift = 1'b1;
          end else begin
            fill_next = fill + FW'(1);
          end
          if (flen_fits && (LW'(fill_next) == flen_x)) begin
            state_next = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (fill < FW'(2)) begin
          // no sync pair anywhere
          fill_next  = '0;
          state_next = S_IDLE;
        end else if (pair_at_head) begin
          if (fill_x == flen_x) begin
            sum_next   = '0;
            rot_next   = '0;
            state_next = S_SUM;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cctrl.shift = 1'b1;
          fill_next   = fill - FW'(1);
        end
      end

      S_SUM: begin
        // one full rotation leaves the buffer where it started
        cctrl.shift = 1'b1;
        if (rot_x < (flen_x - LW'(2))) begin
          sum_next = sum + {8'd0, head0};
        end
        if (rot_x == (flen_x - LW'(2))) begin
          trl_next[15:8] = head0;
        end
        if (rot_x == (flen_x - LW'(1))) begin
          trl_next[7:0] = head0;
        end
        rot_next = rot + IDXW'(1);
        if (rot == IDXW'(MAX_FRAME_BYTES - 1)) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        if (sum == trl) begin
          good_cnt_next = (good_cnt == '1) ? good_cnt : good_cnt + COUNTER_BITS'(1);
          pos_next      = '0;
          state_next    = S_EMIT;
        end else begin
          err_cnt_next = (err_cnt == '1) ? err_cnt : err_cnt + COUNTER_BITS'(1);
          state_next   = S_ERR;
        end
      end

      S_ERR: begin
        if (slot_free) begin
          load        = 1'b1;
          load_status = 1'b1;
          load_value  = trl;
          load_last   = 1'b1;
          cctrl.shift = 1'b1;
          fill_next   = fill - FW'(1);
          state_next  = S_IDLE;
        end
      end

      S_EMIT: begin
        if ((pos < FLEN_W'(2)) || pos[0]) begin
          // skip the sync bytes and the low byte of each sent word
          cctrl.shift = 1'b1;
          pos_next    = pos + FLEN_W'(1);
        end else if (slot_free) begin
          load        = 1'b1;
          load_index  = 4'(pos[FLEN_W-1:1] - (FLEN_W-1)'(1));
          load_last   = emit_last;
          cctrl.shift = 1'b1;
          pos_next    = pos + FLEN_W'(1);
          if (emit_last) begin
            fill_next  = '0;
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // counters clipped to 16 bits for display
  function automatic logic [15:0] show(input logic [COUNTER_BITS-1:0] c);
    logic [CW-1:0] x;
    x = CW'(c);
    return (x > CW'(16'hFFFF)) ? 16'hFFFF : x[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      regs      <= '0;
      good_cnt  <= '0;
      err_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      good_cnt <= good_cnt_next;
      err_cnt  <= err_cnt_next;
      if (cfg_acc && (cfg_index < 3'(NUM_REGS))) begin
        regs[cfg_index] <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    sum <= sum_next;
    trl <= trl_next;
    rot <= rot_next;
    pos <= pos_next;
    if (load) begin
      status               <= load_status;
      value_index          <= load_index;
      raw_value            <= load_value;
      last_value           <= load_last;
      good_frame_count     <= show(good_cnt);
      checksum_error_count <= show(err_cnt);
    end
  end

endmodule

// File: test/imu_binary_frame_deframer_tb.sv
// self-checking testbench for the imu binary frame deframer
`timescale 1ns / 1ps

module imu_binary_frame_deframer_tb;
  import ibfd_pkg::*;

  // block build under test
  localparam int MAX_BYTES     = 34;
  localparam int SETTLE_CYCLES = 3 * MAX_BYTES + 40;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 22;

  // indexes just past the register list, the block must ignore them
  localparam logic [2:0] SPARE_IDX_A = 3'(NUM_REGS);
  localparam logic [2:0] SPARE_IDX_B = 3'(NUM_REGS + 1);

  // shapes of the byte sequences the random traffic is built from
  typedef enum int {
    SEQ_GOOD,
    SEQ_BAD_SUM,
    SEQ_NOISE,
    SEQ_TRUNCATED
  } seq_kind_t;

  // one expected result transaction
  typedef struct packed {
    logic        status;
    logic [3:0]  pos;
    logic [15:0] word;
    logic        last;
    logic [15:0] good_cnt;
    logic [15:0] err_cnt;
  } frame_word_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte    = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        status;
  logic [3:0]  value_index;
  logic [15:0] raw_value;
  logic        last_value;
  logic [15:0] good_frame_count;
  logic [15:0] checksum_error_count;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = 3'd0;
  logic        cfg_data   = 1'b0;

  // predictor state: register copy, byte buffer and the two counters
  logic [NUM_REGS-1:0] cfg_regs = '0;
  logic [7:0]          frame_buf[$];
  logic [15:0]         good_frames  = '0;
  logic [15:0]         sum_errors   = '0;
  frame_word_t         pending_words[$];

  // byte sequence being assembled for sending
  logic [7:0] pkt[$];

  int   mismatches   = 0;
  int   burst_left   = 0;
  logic hold_request = 1'b0;
  int   hold_left    = 0;
  int   stall_span   = 0;
  int   stall_pct    = 0;
  frame_word_t want;

  imu_binary_frame_deframer DUT (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .rx_byte              (rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .status               (status),
    .value_index          (value_index),
    .raw_value            (raw_value),
    .last_value           (last_value),
    .good_frame_count     (good_frame_count),
    .checksum_error_count (checksum_error_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // payload words carried by a frame under the given enables
  function automatic int payload_words(input logic [NUM_REGS-1:0] r);
    int n;
    n = r[REG_QUAT] ? 4 : 3;
    if (r[REG_GYRO])  n += 3;
    if (r[REG_ACCEL]) n += 3;
    if (r[REG_MAG])   n += 3;
    if (r[REG_TEMP])  n += 1;
    if (r[REG_TIME])  n += 1;
    return n;
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] c);
    return (c == '1) ? c : c + 16'd1;
  endfunction

  // one accepted byte: update the buffer and queue whatever it completes
  function automatic void deframe_byte(input logic [7:0] b);
    int          words;
    int          flen;
    int          sync_at;
    logic [15:0] sum;
    logic [15:0] trailer;
    frame_word_t r;
    words = payload_words(cfg_regs);
    flen  = 4 + 2 * words;
    // a full buffer shifts out its oldest byte
    if (frame_buf.size() >= MAX_BYTES) void'(frame_buf.pop_front());
    frame_buf = {frame_buf, b};
    if (flen > MAX_BYTES || frame_buf.size() < flen) return;
    // hunt for the first sync pair
    sync_at = -1;
    for (int i = 0; i + 1 < frame_buf.size(); i++)
      if (sync_at < 0 && frame_buf[i] == SYNC_BYTE && frame_buf[i+1] == SYNC_BYTE)
        sync_at = i;
    if (sync_at < 0) begin
      frame_buf.delete();
      return;
    end
    repeat (sync_at) void'(frame_buf.pop_front());
    if (frame_buf.size() < flen) return;
    sum = '0;
    for (int i = 0; i < flen - 2; i++) sum += 16'(frame_buf[i]);
    trailer = {frame_buf[flen-2], frame_buf[flen-1]};
    if (sum != trailer) begin
      // checksum miss: one error transaction, slide by one byte
      sum_errors = bump(sum_errors);
      void'(frame_buf.pop_front());
      r.status   = 1'b1;
      r.pos      = 4'd0;
      r.word     = trailer;
      r.last     = 1'b1;
      r.good_cnt = good_frames;
      r.err_cnt  = sum_errors;
      pending_words = {pending_words, r};
    end else begin
      good_frames = bump(good_frames);
      for (int i = 0; i < words; i++) begin
        r.status   = 1'b0;
        r.pos      = 4'(i);
        r.word     = {frame_buf[2+2*i], frame_buf[3+2*i]};
        r.last     = (i == words - 1);
        r.good_cnt = good_frames;
        r.err_cnt  = sum_errors;
        pending_words = {pending_words, r};
      end
      repeat (flen) void'(frame_buf.pop_front());
    end
  endfunction

  // ------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // every accepted result transaction is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result transaction with nothing expected: raw_value %0h", raw_value);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("value_index", 16'(want.pos), 16'(value_index));
        check_field("raw_value", want.word, raw_value);
        check_field("last_value", 16'(want.last), 16'(last_value));
        check_field("good_frame_count", want.good_cnt, good_frame_count);
        check_field("checksum_error_count", want.err_cnt, checksum_error_count);
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver stall pattern
  // ------------------------------------------------------------------

  // stall density changes over spans of random length, zero included; a long
  // hold-off is counted here when a test asks for one
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (stall_span == 0) begin
      stall_span = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_span--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------

  // one byte transaction; bursts of random length with random gaps between
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    deframe_byte(b);
  endtask

  task automatic send_pkt(input int first, input int count);
    for (int i = first; i < first + count; i++) send_byte(pkt[i]);
  endtask

  // register write; valid stays up so back-to-back writes need no gap
  task automatic cfg_write(input logic [2:0] idx, input logic d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_REGS) begin
      cfg_regs[idx] = d;
      frame_buf.delete();
    end
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [NUM_REGS-1:0] vals);
    for (int i = 0; i < NUM_REGS; i++) cfg_write(3'(i), vals[i]);
    cfg_done();
  endtask

  // input quiet, every expected result in, then room for a frame end with
  // no output to finish its search and sum pass
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // frame building
  // ------------------------------------------------------------------

  // random byte with the sync value over-represented
  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return ($urandom_range(0, 7) == 0) ? SYNC_BYTE : b;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return {rand_byte(), rand_byte()};
    endcase
  endfunction

  function automatic void start_frame();
    pkt.delete();
    pkt = {pkt, SYNC_BYTE};
    pkt = {pkt, SYNC_BYTE};
  endfunction

  function automatic void add_word(input logic [15:0] w);
    pkt = {pkt, w[15:8]};
    pkt = {pkt, w[7:0]};
  endfunction

  // append the big-endian byte sum of everything so far
  function automatic void close_frame();
    logic [15:0] sum;
    sum = '0;
    foreach (pkt[i]) sum += 16'(pkt[i]);
    add_word(sum);
  endfunction

  function automatic void random_frame();
    start_frame();
    repeat (payload_words(cfg_regs)) add_word(rand_word());
    close_frame();
  endfunction

  // mostly well-formed frames with random content, the rest noise,
  // corrupted sums and frames cut short
  task automatic random_traffic(input int n_items);
    int        sent;
    int        n;
    int        k;
    seq_kind_t kind;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 9);
      kind = (k < 6) ? SEQ_GOOD : (k < 8) ? SEQ_BAD_SUM : (k < 9) ? SEQ_NOISE : SEQ_TRUNCATED;
      random_frame();
      case (kind)
        SEQ_GOOD: n = pkt.size();
        SEQ_BAD_SUM: begin
          k = $urandom_range(2, pkt.size() - 1);
          pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(0, 7));
          n = pkt.size();
        end
        SEQ_NOISE: begin
          pkt.delete();
          repeat ($urandom_range(1, 4)) pkt = {pkt, rand_byte()};
          n = pkt.size();
        end
        default: n = $urandom_range(1, pkt.size() - 1);
      endcase
      send_pkt(0, n);
      sent += n;
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset settings (three words): leading garbage, a good frame with extreme
  // words, a frame whose trailer is off by one bit, then stray bytes
  task automatic test_shortest_frames();
    send_byte(8'h00);
    send_byte(8'hAA);
    start_frame();
    add_word(16'h0000);
    add_word(16'hFFFF);
    add_word(16'h8001);
    close_frame();
    send_pkt(0, pkt.size());
    start_frame();
    add_word(16'hFF00);
    add_word(16'h00FF);
    add_word(16'h5555);
    close_frame();
    pkt[pkt.size()-1] = pkt[pkt.size()-1] ^ 8'h01;
    send_pkt(0, pkt.size());
    send_byte(8'hFF);
    send_byte(8'h00);
    settle();
  endtask

  // a register write drops a half-received frame
  task automatic test_config_write_clears_buffer();
    random_frame();
    send_pkt(0, 5);
    settle();
    cfg_write(REG_QUAT, 1'b0);
    cfg_done();
    random_frame();
    send_pkt(0, pkt.size());
    settle();
  endtask

  // writes past the register list leave the buffer alone
  task automatic test_unlisted_index_ignored();
    random_frame();
    send_pkt(0, 5);
    settle();
    cfg_write(SPARE_IDX_A, 1'b1);
    cfg_write(SPARE_IDX_B, 1'b0);
    cfg_done();
    send_pkt(5, pkt.size() - 5);
    settle();
  endtask

  // several register settings, all-on and all-off among them
  task automatic test_random_settings();
    logic [NUM_REGS-1:0] setting;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       setting = '1;
        1:       setting = '0;
        default: setting = NUM_REGS'($urandom);
      endcase
      write_all_regs(setting);
      random_traffic(PHASE_ITEMS);
      settle();
    end
  endtask

  // receiver holds off for a long stretch while good frames keep coming,
  // so the result register fills and the byte input backs up
  task automatic test_output_hold_off();
    logic [NUM_REGS-1:0] setting;
    setting            = '0;
    setting[REG_GYRO]  = 1'b1;
    setting[REG_ACCEL] = 1'b1;
    write_all_regs(setting);
    hold_request = 1'b1;
    repeat (2) begin
      random_frame();
      send_pkt(0, pkt.size());
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_shortest_frames();
    test_config_write_clears_buffer();
    test_unlisted_index_ignored();
    test_random_settings();
    test_output_hold_off();
    settle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
